// File: sv/lasttl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasttl_pkg
// Shared types and constants for the latched alarm status block.
// ----------------------------------------------------------------------------
package lasttl_pkg;

    localparam int unsigned QDEPTH_DEF = 4;

    localparam logic [15:0] TTL_FLOOR_RST   = 16'd500;
    localparam logic [15:0] TTL_CEILING_RST = 16'd30000;

    typedef enum logic [1:0] {
        LVL_UNKNOWN = 2'd0,
        LVL_SAFE    = 2'd1,
        LVL_ATTACK  = 2'd2
    } t_level;

    typedef enum logic {
        CFG_TTL_FLOOR   = 1'b0,
        CFG_TTL_CEILING = 1'b1
    } t_cfg_index;

    // classified item handed from front to back
    typedef struct packed {
        logic        is_tick;
        logic [31:0] now_ms;
        t_level      level;
        logic [15:0] alerts;
        logic [7:0]  expected;
        logic [7:0]  online;
        logic [31:0] incident;
        logic [15:0] node;
        logic [7:0]  class_code;
        logic [15:0] ttl_ms;
    } t_item;

    typedef struct packed {
        t_level      level;
        logic [15:0] alerts;
        logic [7:0]  expected;
        logic [7:0]  online;
        logic [31:0] incident;
        logic [15:0] node;
        logic [7:0]  class_code;
        logic        has_data;
        logic        is_fresh;
        logic [31:0] age_ms;
        logic [31:0] attack_ms;
        logic [31:0] revision;
    } t_result;

endpackage

// File: sv/lasttl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasttl_front
// Accepts items, resolves the reported level and clamps the validity time.
// ----------------------------------------------------------------------------
module lasttl_front (
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_tick,
    input  logic [31:0]         i_now_ms,
    input  logic [1:0]          i_level_in,
    input  logic [15:0]         i_alerts_in,
    input  logic [7:0]          i_expected_in,
    input  logic [7:0]          i_online_in,
    input  logic [31:0]         i_incident_in,
    input  logic [15:0]         i_node_in,
    input  logic [7:0]          i_class_in,
    input  logic [31:0]         i_ttl_in_ms,
    input  logic [15:0]         i_ttl_floor,
    input  logic [15:0]         i_ttl_ceiling,
    output logic                o_valid,
    input  logic                i_ready,
    output lasttl_pkg::t_item   o_item
);

    lasttl_pkg::t_level lvl;
    logic [15:0]        ttl_min;

    always_comb begin
        case (i_level_in)
            lasttl_pkg::LVL_SAFE:   lvl = lasttl_pkg::LVL_SAFE;
            lasttl_pkg::LVL_ATTACK: lvl = lasttl_pkg::LVL_ATTACK;
            default:                lvl = lasttl_pkg::LVL_UNKNOWN;
        endcase
        if (i_alerts_in != 16'd0) begin
            lvl = lasttl_pkg::LVL_ATTACK;
        end
        if (lvl == lasttl_pkg::LVL_SAFE &&
            (i_expected_in == 8'd0 || i_online_in < i_expected_in)) begin
            lvl = lasttl_pkg::LVL_UNKNOWN;
        end
    end

    assign ttl_min = (i_ttl_in_ms < {16'd0, i_ttl_ceiling}) ? i_ttl_in_ms[15:0] : i_ttl_ceiling;

    always_comb begin
        o_item.is_tick    = i_tick;
        o_item.now_ms     = i_now_ms;
        o_item.level      = lvl;
        o_item.alerts     = i_alerts_in;
        o_item.expected   = i_expected_in;
        o_item.online     = i_online_in;
        o_item.incident   = i_incident_in;
        o_item.node       = i_node_in;
        o_item.class_code = i_class_in;
        o_item.ttl_ms     = (ttl_min > i_ttl_floor) ? ttl_min : i_ttl_floor;
    end

    assign o_valid = i_valid;
    assign o_ready = i_ready;

endmodule

// File: sv/lasttl_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasttl_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module lasttl_fifo #(
    parameter int unsigned DEPTH = lasttl_pkg::QDEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  lasttl_pkg::t_item   i_push_item,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output lasttl_pkg::t_item   o_pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lasttl_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wr_ptr == r_rd_ptr)
        else $error("empty queue with pointers apart");

endmodule

// File: sv/lasttl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasttl_back
// Holds the status record, applies snapshots and ticks, registers results.
// ----------------------------------------------------------------------------
module lasttl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lasttl_pkg::t_item   i_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lasttl_pkg::t_result o_result
);

    lasttl_pkg::t_level r_level,    n_level;
    logic [15:0]        r_alerts,   n_alerts;
    logic [7:0]         r_expected, n_expected;
    logic [7:0]         r_online,   n_online;
    logic [31:0]        r_incident, n_incident;
    logic [15:0]        r_node,     n_node;
    logic [7:0]         r_class,    n_class;
    logic [31:0]        r_start,    n_start;
    logic               r_seen,     n_seen;
    logic               r_fresh,    n_fresh;
    logic [31:0]        r_recv,     n_recv;
    logic [15:0]        r_ttl,      n_ttl;
    logic [31:0]        r_rev,      n_rev;

    lasttl_pkg::t_result r_out;
    logic                r_out_valid;
    lasttl_pkg::t_result res;
    logic                pop;
    logic                was_attack;
    logic [31:0]         age;
    logic [16:0]         ttl_p1;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign pop         = i_in_valid && o_in_ready;
    assign was_attack  = (r_level == lasttl_pkg::LVL_ATTACK);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        n_level    = r_level;
        n_alerts   = r_alerts;
        n_expected = r_expected;
        n_online   = r_online;
        n_incident = r_incident;
        n_node     = r_node;
        n_class    = r_class;
        n_start    = r_start;
        n_seen     = r_seen;
        n_fresh    = r_fresh;
        n_recv     = r_recv;
        n_ttl      = r_ttl;
        n_rev      = r_rev;
        if (pop) begin
            if (!i_item.is_tick) begin
                n_level    = i_item.level;
                n_alerts   = i_item.alerts;
                n_expected = i_item.expected;
                n_online   = i_item.online;
                n_incident = i_item.incident;
                n_node     = i_item.node;
                n_class    = i_item.class_code;
                // hold the latched attack and its identifiers
                if (was_attack && i_item.level != lasttl_pkg::LVL_SAFE) begin
                    n_level = lasttl_pkg::LVL_ATTACK;
                    if (i_item.incident == 32'd0) n_incident = r_incident;
                    if (i_item.node == 16'd0)     n_node     = r_node;
                    if (i_item.class_code == 8'd0) n_class   = r_class;
                end
                if (n_level == lasttl_pkg::LVL_ATTACK) begin
                    if (!was_attack) n_start = i_item.now_ms;
                    if (i_item.alerts == 16'd0) n_alerts = 16'd1;
                end else begin
                    n_start = 32'd0;
                    if (n_level == lasttl_pkg::LVL_SAFE) begin
                        n_incident = 32'd0;
                        n_node     = 16'd0;
                        n_class    = 8'd0;
                    end
                end
                n_seen  = 1'b1;
                n_fresh = 1'b1;
                n_recv  = i_item.now_ms;
                n_ttl   = i_item.ttl_ms;
                n_rev   = r_rev + 32'd1;
            end else if (r_fresh && (i_item.now_ms - r_recv) > {16'd0, r_ttl}) begin
                n_fresh = 1'b0;
            end
        end
    end

    always_comb begin
        ttl_p1 = {1'b0, n_ttl} + 17'd1;
        age    = i_item.now_ms - n_recv;
        if (!n_fresh && age < {15'd0, ttl_p1}) begin
            age = {15'd0, ttl_p1};
        end
        if (!n_seen) begin
            age = 32'd0;
        end
        res.level      = n_level;
        res.alerts     = n_alerts;
        res.expected   = n_expected;
        res.online     = n_online;
        res.incident   = n_incident;
        res.node       = n_node;
        res.class_code = n_class;
        res.has_data   = n_seen;
        res.is_fresh   = n_seen && n_fresh;
        res.age_ms     = age;
        res.attack_ms  = (n_level == lasttl_pkg::LVL_ATTACK) ? i_item.now_ms - n_start : 32'd0;
        res.revision   = n_rev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= lasttl_pkg::LVL_UNKNOWN;
            r_alerts   <= '0;
            r_expected <= '0;
            r_online   <= '0;
            r_incident <= '0;
            r_node     <= '0;
            r_class    <= '0;
            r_start    <= '0;
            r_seen     <= 1'b0;
            r_fresh    <= 1'b0;
            r_recv     <= '0;
            r_ttl      <= '0;
            r_rev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_level    <= n_level;
            r_alerts   <= n_alerts;
            r_expected <= n_expected;
            r_online   <= n_online;
            r_incident <= n_incident;
            r_node     <= n_node;
            r_class    <= n_class;
            r_start    <= n_start;
            r_seen     <= n_seen;
            r_fresh    <= n_fresh;
            r_recv     <= n_recv;
            r_ttl      <= n_ttl;
            r_rev      <= n_rev;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= res;
        end
    end

    a_attack_alerts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.level == lasttl_pkg::LVL_ATTACK |-> r_out.alerts != 16'd0)
        else $error("attack result without alerts");

    a_fresh_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh |-> r_seen)
        else $error("fresh flag without data");

    a_rev_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_item.is_tick |=> r_rev == $past(r_rev) + 32'd1)
        else $error("revision not advanced on snapshot");

    a_safe_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level == lasttl_pkg::LVL_SAFE |-> r_incident == 32'd0 && r_start == 32'd0)
        else $error("safe status keeps attack data");

endmodule

// File: sv/latched_alarm_status_with_ttl.sv
`timescale 1ns / 1ps
// A result is registered in the queue and then in the back stage output register; an output stall can hold it.
// Throughput: one item per cycle unless the output stalls; the back stage applies one record update per cycle.
// The four-entry queue lets input transfers continue while the output is stalled.
// Reset (synchronous, active low) clears the record and queue, floor 500 ms, ceiling 30000 ms.
// ----------------------------------------------------------------------------
// latched_alarm_status_with_ttl
// Latched security status record with validity time, age and attack duration.
// ----------------------------------------------------------------------------
module latched_alarm_status_with_ttl #(
    parameter int unsigned QDEPTH = lasttl_pkg::QDEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // now_ms[31:0] level_in[33:32] alerts_in[49:34] expected_in[57:50] online_in[65:58]
    // incident_in[97:66] node_in[113:98] class_in[121:114] ttl_in_ms[153:122], zero pad
    input  logic [159:0] i_s_axis_tdata,
    // req_type[0]
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // level_out[1:0] alerts_out[17:2] expected_out[25:18] online_out[33:26]
    // incident_out[65:34] node_out[81:66] class_out[89:82] has_data[90] is_fresh[91]
    // age_ms[123:92] attack_ms[155:124] revision_out[187:156], zero pad
    output logic [191:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    logic [15:0]         r_ttl_floor;
    logic [15:0]         r_ttl_ceiling;
    logic                front_valid;
    logic                front_ready;
    lasttl_pkg::t_item   front_item;
    logic                q_valid;
    logic                q_ready;
    lasttl_pkg::t_item   q_item;
    lasttl_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl_floor   <= lasttl_pkg::TTL_FLOOR_RST;
            r_ttl_ceiling <= lasttl_pkg::TTL_CEILING_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lasttl_pkg::CFG_TTL_FLOOR:   r_ttl_floor   <= i_cfg_data;
                lasttl_pkg::CFG_TTL_CEILING: r_ttl_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lasttl_front u_front (
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_tick        (i_s_axis_tuser),
        .i_now_ms      (i_s_axis_tdata[31:0]),
        .i_level_in    (i_s_axis_tdata[33:32]),
        .i_alerts_in   (i_s_axis_tdata[49:34]),
        .i_expected_in (i_s_axis_tdata[57:50]),
        .i_online_in   (i_s_axis_tdata[65:58]),
        .i_incident_in (i_s_axis_tdata[97:66]),
        .i_node_in     (i_s_axis_tdata[113:98]),
        .i_class_in    (i_s_axis_tdata[121:114]),
        .i_ttl_in_ms   (i_s_axis_tdata[153:122]),
        .i_ttl_floor   (r_ttl_floor),
        .i_ttl_ceiling (r_ttl_ceiling),
        .o_valid       (front_valid),
        .i_ready       (front_ready),
        .o_item        (front_item)
    );

    lasttl_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    lasttl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (q_valid),
        .o_in_ready  (q_ready),
        .i_item      (q_item),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (result)
    );

    assign o_m_axis_tdata = {
        4'd0,
        result.revision,
        result.attack_ms,
        result.age_ms,
        result.is_fresh,
        result.has_data,
        result.class_code,
        result.node,
        result.incident,
        result.online,
        result.expected,
        result.alerts,
        result.level
    };

endmodule

// File: tb/tb_latched_alarm_status_with_ttl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_latched_alarm_status_with_ttl
// Self-checking bench for the latched alarm status record. A directed table
// covers reset, level resolution, attack latching, identifier inheritance,
// validity clamping and clock wrap; random snapshot and tick traffic then runs
// under several floor and ceiling settings. Each result transfer is checked
// field by field against an in-bench status predictor, with bursty input,
// patterned output stalls, one long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_latched_alarm_status_with_ttl;

    localparam logic        REQ_SNAPSHOT     = 1'b0;
    localparam logic        REQ_TICK         = 1'b1;
    localparam logic [1:0]  LEVEL_UNKNOWN    = lasttl_pkg::LVL_UNKNOWN;
    localparam logic [1:0]  LEVEL_SAFE       = lasttl_pkg::LVL_SAFE;
    localparam logic [1:0]  LEVEL_ATTACK     = lasttl_pkg::LVL_ATTACK;
    localparam logic [1:0]  LEVEL_CODE_THREE = 2'd3;
    localparam int unsigned RANDOM_PER_PHASE = 150;
    localparam int unsigned NUM_PHASES       = 6;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned HOLD_AFTER       = 250;
    localparam int unsigned HOLD_CYCLES      = 80;
    localparam int unsigned DIR_ROWS         = 22;

    typedef struct packed {
        logic        is_tick;
        logic [31:0] now;
        logic [1:0]  level;
        logic [15:0] alerts;
        logic [7:0]  expct;
        logic [7:0]  onl;
        logic [31:0] incident;
        logic [15:0] node;
        logic [7:0]  cls;
        logic [31:0] ttl_req;
    } t_status_req;

    typedef struct packed {
        logic                use_lit;
        lasttl_pkg::t_result lit;
        t_status_req         req;
    } t_dir_row;

    localparam lasttl_pkg::t_result NO_RESULT = '0;

    localparam t_dir_row DIR_TABLE [0:DIR_ROWS-1] = '{
        '{1'b1, NO_RESULT, '{REQ_TICK, 32'd0, LEVEL_UNKNOWN, 16'd0, 8'd0, 8'd0,
                              32'd0, 16'd0, 8'd0, 32'd0}},
        '{1'b1, NO_RESULT, '{REQ_TICK, 32'hFFFF_FFFF, LEVEL_CODE_THREE, 16'hFFFF, 8'hFF,
                              8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}},
        '{1'b1, '{lasttl_pkg::LVL_SAFE, 16'd0, 8'd4, 8'd4, 32'd0, 16'd0, 8'd0, 1'b1, 1'b1,
                  32'd0, 32'd0, 32'd1},
                '{REQ_SNAPSHOT, 32'd1000, LEVEL_SAFE, 16'd0, 8'd4, 8'd4,
                  32'h1234, 16'd7, 8'd3, 32'd1000}},
        '{1'b0, NO_RESULT, '{REQ_TICK, 32'd1500, LEVEL_UNKNOWN, 16'd0, 8'd0, 8'd0,
                              32'd0, 16'd0, 8'd0, 32'd0}},
        '{1'b0, NO_RESULT, '{REQ_TICK, 32'd2001, LEVEL_UNKNOWN, 16'd0, 8'd0, 8'd0,
                              32'd0, 16'd0, 8'd0, 32'd0}},
        '{1'b0, NO_RESULT, '{REQ_TICK, 32'd2002, LEVEL_ATTACK, 16'd5, 8'd1, 8'd1,
                              32'd1, 16'd1, 8'd1, 32'd1}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'd3000, LEVEL_SAFE, 16'd0, 8'd0, 8'd0,
                              32'hA5A5, 16'h11, 8'h22, 32'd0}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'd3100, LEVEL_SAFE, 16'd0, 8'd5, 8'd4,
                              32'd0, 16'd0, 8'd0, 32'hFFFF_FFFF}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'd3200, LEVEL_CODE_THREE, 16'd0, 8'd2, 8'd2,
                              32'd1, 16'd1, 8'd1, 32'd700}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'd4000, LEVEL_UNKNOWN, 16'hFFFF, 8'd3, 8'd1,
                              32'hDEAD_BEEF, 16'hBEEF, 8'h42, 32'd2000}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'd4100, LEVEL_SAFE, 16'd1, 8'd3, 8'd3,
                              32'd0, 16'd0, 8'd0, 32'd2000}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'd4200, LEVEL_UNKNOWN, 16'd0, 8'd3, 8'd2,
                              32'd0, 16'd9, 8'd0, 32'd2000}},
        '{1'b0, NO_RESULT, '{REQ_TICK, 32'd50000, LEVEL_SAFE, 16'h1234, 8'h55, 8'hAA,
                              32'h5555_AAAA, 16'hAAAA, 8'h55, 32'd7}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'd60000, LEVEL_SAFE, 16'd0, 8'hFF, 8'hFF,
                              32'd5, 16'd6, 8'd7, 32'd30000}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'hFFFF_FFF0, LEVEL_UNKNOWN, 16'd0, 8'd0, 8'd0,
                              32'd77, 16'd88, 8'd99, 32'd100}},
        '{1'b0, NO_RESULT, '{REQ_TICK, 32'd16, LEVEL_UNKNOWN, 16'd0, 8'd0, 8'd0,
                              32'd0, 16'd0, 8'd0, 32'd0}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'hFFFF_FFFE, LEVEL_ATTACK, 16'd0, 8'd2, 8'd2,
                              32'd0, 16'd0, 8'd0, 32'd1000}},
        '{1'b0, NO_RESULT, '{REQ_TICK, 32'd5, LEVEL_UNKNOWN, 16'd0, 8'd0, 8'd0,
                              32'd0, 16'd0, 8'd0, 32'd0}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'hFFFF_FFFF, LEVEL_CODE_THREE, 16'hFFFF, 8'hFF,
                              8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'd0, LEVEL_UNKNOWN, 16'd0, 8'd0, 8'd0,
                              32'd0, 16'd0, 8'd0, 32'd0}},
        '{1'b0, NO_RESULT, '{REQ_SNAPSHOT, 32'd100, LEVEL_SAFE, 16'd0, 8'd1, 8'hC8,
                              32'd3, 16'd3, 8'd3, 32'd30001}},
        '{1'b0, NO_RESULT, '{REQ_TICK, 32'h8000_0000, LEVEL_UNKNOWN, 16'd0, 8'd0, 8'd0,
                              32'd0, 16'd0, 8'd0, 32'd0}}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [159:0]           s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    lasttl_pkg::t_cfg_index cfg_index = lasttl_pkg::CFG_TTL_FLOOR;
    logic [15:0]            cfg_data  = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [191:0]           o_m_axis_tdata;
    logic                   o_cfg_ready;

    // status predictor
    logic [15:0]        cfg_floor     = lasttl_pkg::TTL_FLOOR_RST;
    logic [15:0]        cfg_ceiling   = lasttl_pkg::TTL_CEILING_RST;
    lasttl_pkg::t_level rec_level     = lasttl_pkg::LVL_UNKNOWN;
    logic [15:0]        rec_alerts    = '0;
    logic [7:0]         rec_expected  = '0;
    logic [7:0]         rec_online    = '0;
    logic [31:0]        rec_incident  = '0;
    logic [15:0]        rec_node      = '0;
    logic [7:0]         rec_class     = '0;
    logic [31:0]        rec_atk_start = '0;
    logic               rec_seen      = 1'b0;
    logic               rec_fresh     = 1'b0;
    logic [31:0]        rec_rx_at     = '0;
    logic [15:0]        rec_ttl       = '0;
    logic [31:0]        rec_rev       = '0;

    lasttl_pkg::t_result pending_status [$];
    lasttl_pkg::t_result got_status;
    lasttl_pkg::t_result want_status;
    logic [31:0]    now_clk      = '0;
    int unsigned    n_errors     = 0;
    int unsigned    n_snap       = 0;
    int unsigned    n_tick       = 0;
    int unsigned    n_attack_out = 0;
    int unsigned    n_stale_out  = 0;
    int unsigned    idle_cycles  = 0;
    int unsigned    burst_left   = 0;

    // receiver pattern state
    int unsigned    rx_count  = 0;
    int unsigned    rx_mode   = 0;
    int unsigned    mode_left = 0;
    int unsigned    hold_left = 0;
    logic           hold_done = 1'b0;
    logic [2:0]     rx_phase  = '0;

    latched_alarm_status_with_ttl uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic lasttl_pkg::t_result advance_status(input t_status_req r);
        logic                was_attack;
        logic [1:0]          lvl;
        logic [15:0]         al;
        logic [31:0]         inc;
        logic [15:0]         nd;
        logic [7:0]          cl;
        logic [31:0]         lim;
        logic [31:0]         age;
        lasttl_pkg::t_result res;
        if (r.is_tick == REQ_SNAPSHOT) begin
            was_attack = (rec_level == lasttl_pkg::LVL_ATTACK);
            lvl = (r.level == LEVEL_CODE_THREE) ? LEVEL_UNKNOWN : r.level;
            al  = r.alerts;
            inc = r.incident;
            nd  = r.node;
            cl  = r.cls;
            if (al != 16'd0)
                lvl = LEVEL_ATTACK;
            if (lvl == LEVEL_SAFE && (r.expct == 8'd0 || r.onl < r.expct))
                lvl = LEVEL_UNKNOWN;
            if (was_attack && lvl != LEVEL_SAFE) begin
                lvl = LEVEL_ATTACK;
                if (inc == 32'd0) inc = rec_incident;
                if (nd == 16'd0) nd = rec_node;
                if (cl == 8'd0) cl = rec_class;
            end
            if (lvl == LEVEL_ATTACK) begin
                if (!was_attack)
                    rec_atk_start = r.now;
                if (al == 16'd0)
                    al = 16'd1;
            end else begin
                rec_atk_start = 32'd0;
                if (lvl == LEVEL_SAFE) begin
                    inc = 32'd0;
                    nd  = 16'd0;
                    cl  = 8'd0;
                end
            end
            rec_level    = lasttl_pkg::t_level'(lvl);
            rec_alerts   = al;
            rec_expected = r.expct;
            rec_online   = r.onl;
            rec_incident = inc;
            rec_node     = nd;
            rec_class    = cl;
            rec_seen     = 1'b1;
            rec_fresh    = 1'b1;
            rec_rx_at    = r.now;
            lim = (r.ttl_req < {16'd0, cfg_ceiling}) ? r.ttl_req : {16'd0, cfg_ceiling};
            if (lim < {16'd0, cfg_floor})
                lim = {16'd0, cfg_floor};
            rec_ttl = lim[15:0];
            rec_rev = rec_rev + 32'd1;
            n_snap++;
        end else begin
            if (rec_fresh && (r.now - rec_rx_at) > {16'd0, rec_ttl})
                rec_fresh = 1'b0;
            n_tick++;
        end
        age = 32'd0;
        if (rec_seen) begin
            age = r.now - rec_rx_at;
            if (!rec_fresh && age < {16'd0, rec_ttl} + 32'd1)
                age = {16'd0, rec_ttl} + 32'd1;
        end
        res.level      = rec_level;
        res.alerts     = rec_alerts;
        res.expected   = rec_expected;
        res.online     = rec_online;
        res.incident   = rec_incident;
        res.node       = rec_node;
        res.class_code = rec_class;
        res.has_data   = rec_seen;
        res.is_fresh   = rec_seen && rec_fresh;
        res.age_ms     = age;
        res.attack_ms  = (rec_level == lasttl_pkg::LVL_ATTACK) ? r.now - rec_atk_start : 32'd0;
        res.revision   = rec_rev;
        return res;
    endfunction

    function automatic lasttl_pkg::t_result unpack_status(input logic [191:0] d);
        lasttl_pkg::t_result s;
        s.level      = lasttl_pkg::t_level'(d[1:0]);
        s.alerts     = d[17:2];
        s.expected   = d[25:18];
        s.online     = d[33:26];
        s.incident   = d[65:34];
        s.node       = d[81:66];
        s.class_code = d[89:82];
        s.has_data   = d[90];
        s.is_fresh   = d[91];
        s.age_ms     = d[123:92];
        s.attack_ms  = d[155:124];
        s.revision   = d[187:156];
        return s;
    endfunction

    function automatic t_status_req random_req();
        t_status_req r;
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            now_clk = $urandom;
        else if (pick < 6)
            now_clk = now_clk + $urandom_range(0, 60);
        else if (pick < 12)
            now_clk = now_clk + $urandom_range(0, 1200);
        else
            now_clk = now_clk + $urandom_range(0, 70000);
        r.now     = now_clk;
        r.is_tick = ($urandom_range(0, 2) == 0) ? REQ_TICK : REQ_SNAPSHOT;
        r.level   = 2'($urandom_range(0, 3));
        pick      = $urandom_range(0, 9);
        r.alerts  = (pick < 6) ? 16'd0 : (pick < 8) ? 16'($urandom_range(1, 9)) : 16'($urandom);
        r.expct   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
        if ($urandom_range(0, 1) == 0)
            r.onl = r.expct;
        else
            r.onl = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
        if ($urandom_range(0, 3) == 0) begin
            r.level  = LEVEL_SAFE;
            r.alerts = 16'd0;
            r.expct  = 8'($urandom_range(1, 255));
            r.onl    = r.expct;
        end
        r.incident = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom);
        r.node     = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        r.cls      = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
        case ($urandom_range(0, 3))
            0: r.ttl_req = $urandom_range(0, 2000);
            1: r.ttl_req = $urandom;
            2: r.ttl_req = $urandom_range(0, 65535);
            default: r.ttl_req = $urandom_range(25000, 40000);
        endcase
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // hold valid high; return at the edge where the transfer happens
    task automatic offer_req(input t_status_req r);
        s_tvalid <= 1'b1;
        s_tuser  <= r.is_tick;
        s_tdata  <= {6'd0, r.ttl_req, r.cls, r.node, r.incident, r.onl, r.expct,
                     r.alerts, r.level, r.now};
        do @(posedge clk); while (!o_s_axis_tready);
        pending_status.push_back(advance_status(r));
    endtask

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic drain_results();
        while (pending_status.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input lasttl_pkg::t_cfg_index idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        if (idx == lasttl_pkg::CFG_TTL_FLOOR)
            cfg_floor = val;
        else
            cfg_ceiling = val;
    endtask

    initial begin : stimulus
        int unsigned p;
        int unsigned k;
        t_status_req req;
        logic [15:0] fl;
        logic [15:0] cl;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            offer_req(DIR_TABLE[k].req);
            if (DIR_TABLE[k].use_lit) begin
                void'(pending_status.pop_back());
                pending_status.push_back(DIR_TABLE[k].lit);
            end
            pace_sender();
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            s_tvalid <= 1'b0;
            drain_results();
            case (p)
                0: begin fl = 16'd0;      cl = 16'hFFFF; end
                1: begin fl = 16'hFFFF;   cl = 16'd0;    end
                2: begin fl = 16'd0;      cl = 16'd0;    end
                3: begin fl = 16'hFFFF;   cl = 16'hFFFF; end
                4: begin fl = 16'($urandom); cl = 16'($urandom); end
                default: begin
                    fl = lasttl_pkg::TTL_FLOOR_RST;
                    cl = lasttl_pkg::TTL_CEILING_RST;
                end
            endcase
            write_reg(lasttl_pkg::CFG_TTL_FLOOR, fl);
            write_reg(lasttl_pkg::CFG_TTL_CEILING, cl);
            cfg_valid <= 1'b0;
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                req = random_req();
                offer_req(req);
                if (p == 3 && k == RANDOM_PER_PHASE / 2) begin
                    s_tvalid <= 1'b0;
                    drain_results();
                end else begin
                    pace_sender();
                end
            end
        end

        s_tvalid <= 1'b0;
        drain_results();
        repeat (4) @(posedge clk);
        if (pending_status.size() != 0) begin
            $display("%0t ns: %0d results never arrived", $time, pending_status.size());
            n_errors++;
        end
        $display("Run covered %0d snapshots and %0d ticks over %0d threshold settings.",
                 n_snap, n_tick, NUM_PHASES + 1);
        $display("Results seen: %0d in attack, %0d stale.", n_attack_out, n_stale_out);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            got_status = unpack_status(o_m_axis_tdata);
            if (got_status.level == lasttl_pkg::LVL_ATTACK)
                n_attack_out++;
            if (got_status.has_data && !got_status.is_fresh)
                n_stale_out++;
            if (pending_status.size() == 0) begin
                $display("%0t ns: result transfer with nothing expected, actual %0h",
                         $time, o_m_axis_tdata);
                n_errors++;
            end else begin
                want_status = pending_status.pop_front();
                cmp_field("level", 32'(want_status.level), 32'(got_status.level));
                cmp_field("alerts", 32'(want_status.alerts), 32'(got_status.alerts));
                cmp_field("expected", 32'(want_status.expected), 32'(got_status.expected));
                cmp_field("online", 32'(want_status.online), 32'(got_status.online));
                cmp_field("incident", want_status.incident, got_status.incident);
                cmp_field("node", 32'(want_status.node), 32'(got_status.node));
                cmp_field("class", 32'(want_status.class_code), 32'(got_status.class_code));
                cmp_field("has_data", 32'(want_status.has_data), 32'(got_status.has_data));
                cmp_field("is_fresh", 32'(want_status.is_fresh), 32'(got_status.is_fresh));
                cmp_field("age_ms", want_status.age_ms, got_status.age_ms);
                cmp_field("attack_ms", want_status.attack_ms, got_status.attack_ms);
                cmp_field("revision", want_status.revision, got_status.revision);
            end
        end
    end

    // receiver: patterned stalls plus one long hold-off
    always @(posedge clk) begin
        if (o_m_axis_tvalid && m_tready)
            rx_count <= rx_count + 1;
        if (!hold_done && rx_count >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= $urandom_range(0, 3);
                mode_left <= $urandom_range(8, 80);
            end else begin
                mode_left <= mode_left - 1;
            end
            rx_phase <= rx_phase + 3'd1;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_phase != 3'd0);
            endcase
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)
            || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: latched_alarm_status_with_ttl.f
sv/lasttl_pkg.sv
sv/lasttl_front.sv
sv/lasttl_fifo.sv
sv/lasttl_back.sv
sv/latched_alarm_status_with_ttl.sv
tb/tb_latched_alarm_status_with_ttl.sv
